/* hw/rtl/cca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cca_pkg;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_NUM_CLUSTERS = 1'd0,
    REG_VERTICES     = 1'd1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD_WAIT,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam int unsigned SumW = 32;
  localparam int unsigned CntW = 17;
  localparam int unsigned PosW = 16;

endpackage
`default_nettype wire

/* hw/rtl/cca_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
module cca_divider (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [cca_pkg::SumW-1:0] dividend_i,
  input  wire logic [cca_pkg::CntW-1:0]       divisor_i,
  output logic                               done_o,
  output logic signed [cca_pkg::PosW-1:0]     mean_o
);

  localparam int unsigned SW = cca_pkg::SumW;
  localparam int unsigned CW = cca_pkg::CntW;
  localparam int unsigned BW = $clog2(SW + 1);

  logic [SW-1:0]   quot_q, quot_d;
  logic [CW:0]     rem_q, rem_d;
  logic [CW-1:0]   den_q;
  logic            neg_q;
  logic [BW-1:0]   bit_q, bit_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CW:0]     trial;
  logic [SW:0]     mag;
  logic [SW:0]     sq;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    bit_d  = bit_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[CW-1:0], quot_q[SW-1]};
    if (run_q) begin
      quot_d = {quot_q[SW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d     = trial - {1'b0, den_q};
        quot_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      bit_d = bit_q - BW'(1);
      if (bit_q == BW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= done_d;
      if (start_i) begin
        run_q <= 1'b1;
        bit_q <= BW'(SW);
      end else begin
        run_q <= run_d;
        bit_q <= bit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i[SW-1] ? SW'(-dividend_i) : dividend_i;
      rem_q  <= '0;
      den_q  <= divisor_i;
      neg_q  <= dividend_i[SW-1];
    end else begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  always_comb begin
    mag = {1'b0, quot_q};
    sq = neg_q ? (SW+1)'(-mag) : mag;
    if ($signed(sq) > $signed((SW+1)'(32767))) begin
      mean_o = 16'sh7fff;
    end else if ($signed(sq) < -$signed((SW+1)'(32768))) begin
      mean_o = 16'sh8000;
    end else begin
      mean_o = sq[cca_pkg::PosW-1:0];
    end
  end

  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_no_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("divider busy at done");
  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> rem_q < {1'b0, den_q}) else $error("remainder too big");
`endif

endmodule
`default_nettype wire

/* hw/rtl/cluster_centroid_accumulator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Accumulate items: one per cycle while busy is low; the slot is read at the accepting edge and
// written back at the next edge, with forwarding from the write-back stage.
// Read items: the result strobe follows three 32-step divisions run one after another; an empty
// or invalid slot skips the divisions and answers without them.
// Clear items and reset: a clearing pass over all MAX_CLUSTERS*MAX_VERTICES slots, busy throughout.
// Results are shown for one cycle under result_valid_o; the receiver cannot stall.
module cluster_centroid_accumulator #(
  parameter int unsigned MAX_CLUSTERS = 64,
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_STRANDS  = 65536
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          operation_i,
  input  wire logic signed [6:0]   cluster_id_i,
  input  wire logic [3:0]          vertex_index_i,
  input  wire logic signed [15:0]  pos_x_i,
  input  wire logic signed [15:0]  pos_y_i,
  input  wire logic signed [15:0]  pos_z_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [6:0]          cfg_data_i,
  output logic                     result_valid_o,
  output logic signed [15:0]       mean_x_o,
  output logic signed [15:0]       mean_y_o,
  output logic signed [15:0]       mean_z_o,
  output logic [16:0]              member_count_o,
  output logic                     empty_cluster_o
);

  localparam int unsigned SW    = cca_pkg::SumW;
  localparam int unsigned CW    = cca_pkg::CntW;
  localparam int unsigned CB    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned VB    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned DEPTH = MAX_CLUSTERS * MAX_VERTICES;
  localparam int unsigned AB    = $clog2(DEPTH + 1);
  localparam int unsigned CAP   = (MAX_STRANDS > 131071) ? 131071 : MAX_STRANDS;
  localparam int unsigned SB    = CB + VB;

  logic [6:0] nclu_q;
  logic [4:0] nvert_q;
  cca_pkg::state_e state_q, state_d;
  logic [AB-1:0] clr_q, clr_d;
  logic [1:0] dsel_q, dsel_d;
  logic div_run_q;

  logic [SW-1:0] mem_x [DEPTH];
  logic [SW-1:0] mem_y [DEPTH];
  logic [SW-1:0] mem_z [DEPTH];
  logic [CW-1:0] mem_c [MAX_CLUSTERS];

  // address of an in-range slot: cluster*MAX_VERTICES + vertex
  logic          ok;
  logic [SB-1:0] addr;
  logic [CB-1:0] cidx;
  logic [7:0]    cid_ext;

  assign cid_ext = {1'b0, cluster_id_i[6:0]};
  always_comb begin
    ok = !cluster_id_i[6]
      && (32'(cluster_id_i[5:0]) < MAX_CLUSTERS)
      && ({1'b0, cluster_id_i[5:0]} < nclu_q)
      && (32'(vertex_index_i) < MAX_VERTICES)
      && ({1'b0, vertex_index_i} < nvert_q);
    cidx = CB'(cid_ext);
    addr = SB'(32'(cidx) * MAX_VERTICES + 32'(vertex_index_i));
  end

  // stage 1: read issued; stage 2: add and write back
  logic          s1_v_q, s1_cnt_q;
  logic [SB-1:0] s1_a_q;
  logic [CB-1:0] s1_c_q;
  logic signed [15:0] s1_x_q, s1_y_q, s1_z_q;
  logic [SW-1:0] rd_x_q, rd_y_q, rd_z_q;
  logic [CW-1:0] rd_c_q;
  logic          w_v_q, w_cnt_q;
  logic [SB-1:0] w_a_q;
  logic [CB-1:0] w_c_q;
  logic [SW-1:0] w_x_q, w_y_q, w_z_q;
  logic [CW-1:0] w_cv_q;

  logic          acc_go, rd_go, clr_go;
  logic [SW-1:0] ox, oy, oz, nx, ny, nz;
  logic [CW-1:0] oc, nc;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [15:0] b);
    logic signed [SW:0] s;
    s = $signed({a[SW-1], a}) + $signed({{(SW-15){b[15]}}, b});
    if (s[SW] != s[SW-1]) return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    return s[SW-1:0];
  endfunction

  always_comb begin
    ox = rd_x_q; oy = rd_y_q; oz = rd_z_q; oc = rd_c_q;
    if (w_v_q && w_a_q == s1_a_q) begin
      ox = w_x_q; oy = w_y_q; oz = w_z_q;
    end
    if (w_v_q && w_cnt_q && w_c_q == s1_c_q) oc = w_cv_q;
    nx = sat_add(ox, s1_x_q);
    ny = sat_add(oy, s1_y_q);
    nz = sat_add(oz, s1_z_q);
    nc = (s1_cnt_q && 32'(oc) < CAP) ? oc + CW'(1) : oc;
  end

  // divider
  logic          dv_start, dv_done;
  logic [SW-1:0] dv_num;
  logic signed [15:0] dv_mean;
  logic signed [15:0] mx_q, my_q, mz_q;
  logic [CW-1:0] rc_q;
  logic          rok_q;
  logic [SW-1:0] rx_q, ry_q, rz_q;

  cca_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_num),
    .divisor_i  (rc_q),
    .done_o     (dv_done),
    .mean_o     (dv_mean)
  );

  always_comb begin
    case (dsel_d)
      2'd0:    dv_num = rx_q;
      2'd1:    dv_num = ry_q;
      default: dv_num = rz_q;
    endcase
  end

  assign acc_go = start && !busy && operation_i == cca_pkg::OP_ACCUM && ok;
  assign rd_go  = start && !busy && operation_i == cca_pkg::OP_READ;
  assign clr_go = start && !busy && operation_i == cca_pkg::OP_CLEAR;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    dsel_d   = dsel_q;
    dv_start = 1'b0;
    busy     = 1'b1;
    case (state_q)
      cca_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (clr_go) begin
          state_d = cca_pkg::ST_CLEAR;
          clr_d   = '0;
        end else if (rd_go) begin
          state_d = cca_pkg::ST_RD_WAIT;
        end
      end
      cca_pkg::ST_CLEAR: begin
        clr_d = clr_q + AB'(1);
        if (32'(clr_q) == DEPTH - 1) state_d = cca_pkg::ST_IDLE;
      end
      cca_pkg::ST_RD_WAIT: begin
        state_d = cca_pkg::ST_DIV;
        dsel_d  = 2'd0;
      end
      cca_pkg::ST_DIV: begin
        if (!rok_q || rc_q == '0) begin
          state_d = cca_pkg::ST_DONE;
        end else if (dsel_q == 2'd0 && !dv_done && !div_run_q) begin
          dv_start = 1'b1;
        end else if (dv_done) begin
          dsel_d = dsel_q + 2'd1;
          if (dsel_q == 2'd2) state_d = cca_pkg::ST_DONE;
          else dv_start = 1'b1;
        end
      end
      cca_pkg::ST_DONE: state_d = cca_pkg::ST_IDLE;
      default: state_d = cca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_run_q <= 1'b0;
    else if (dv_start) div_run_q <= 1'b1;
    else if (state_q != cca_pkg::ST_DIV) div_run_q <= 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cca_pkg::ST_CLEAR;
      clr_q   <= '0;
      dsel_q  <= '0;
      nclu_q  <= 7'd64;
      nvert_q <= 5'd16;
      s1_v_q  <= 1'b0;
      w_v_q   <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      dsel_q  <= dsel_d;
      s1_v_q  <= acc_go;
      w_v_q   <= s1_v_q;
      result_valid_o <= state_q == cca_pkg::ST_DONE;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == cca_pkg::REG_NUM_CLUSTERS) nclu_q <= cfg_data_i;
        else nvert_q <= cfg_data_i[4:0];
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [SB-1:0] raddr;
  assign raddr = acc_go || rd_go ? addr : s1_a_q;

  always_ff @(posedge clk_i) begin
    s1_a_q   <= addr;
    s1_c_q   <= cidx;
    s1_cnt_q <= vertex_index_i == '0;
    s1_x_q   <= pos_x_i;
    s1_y_q   <= pos_y_i;
    s1_z_q   <= pos_z_i;
    if (acc_go || rd_go) begin
      rd_x_q <= mem_x[raddr];
      rd_y_q <= mem_y[raddr];
      rd_z_q <= mem_z[raddr];
      rd_c_q <= mem_c[cidx];
    end
    if (rd_go) rok_q <= ok;
    w_a_q   <= s1_a_q;
    w_c_q   <= s1_c_q;
    w_cnt_q <= s1_cnt_q;
    w_x_q   <= nx;
    w_y_q   <= ny;
    w_z_q   <= nz;
    w_cv_q  <= nc;
    if (state_q == cca_pkg::ST_CLEAR) begin
      mem_x[SB'(clr_q)] <= '0;
      mem_y[SB'(clr_q)] <= '0;
      mem_z[SB'(clr_q)] <= '0;
      if (32'(clr_q) < MAX_CLUSTERS) mem_c[CB'(clr_q)] <= '0;
    end else if (s1_v_q) begin
      mem_x[s1_a_q] <= nx;
      mem_y[s1_a_q] <= ny;
      mem_z[s1_a_q] <= nz;
      if (s1_cnt_q) mem_c[s1_c_q] <= nc;
    end
    if (state_q == cca_pkg::ST_RD_WAIT) begin
      rx_q <= ox; ry_q <= oy; rz_q <= oz; rc_q <= oc;
    end
    if (dv_done) begin
      case (dsel_q)
        2'd0:    mx_q <= dv_mean;
        2'd1:    my_q <= dv_mean;
        default: mz_q <= dv_mean;
      endcase
    end
  end

  logic empty;
  assign empty = !rok_q || rc_q == '0;
  assign mean_x_o = empty ? '0 : mx_q;
  assign mean_y_o = empty ? '0 : my_q;
  assign mean_z_o = empty ? '0 : mz_q;
  assign member_count_o  = empty ? '0 : rc_q;
  assign empty_cluster_o = empty;

`ifndef NO_ASSERTIONS
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> $past(state_q) == cca_pkg::ST_IDLE) else $error("accumulate while busy");
  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result held");
  a_res_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == cca_pkg::ST_DONE) else $error("stray result");
`endif

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic signed [15:0] mean_z;
    logic [16:0]        member_count;
    logic               empty_cluster;
  } centroid_t;

  class centroid_scoreboard;
    longint      sum_x[1024];
    longint      sum_y[1024];
    longint      sum_z[1024];
    int unsigned members[64];
    int unsigned n_clusters;
    int unsigned n_vertices;
    centroid_t   waiting[$];
    int          errors;
    int          items_seen;
    int          reads_checked;

    function new();
      clear_all();
      n_clusters = 64;
      n_vertices = 16;
      errors = 0;
      items_seen = 0;
      reads_checked = 0;
    endfunction

    function void clear_all();
      foreach (sum_x[k]) begin
        sum_x[k] = 0;
        sum_y[k] = 0;
        sum_z[k] = 0;
      end
      foreach (members[c]) members[c] = 0;
    endfunction

    function void set_reg(cca_pkg::reg_e idx, logic [6:0] data);
      if (idx == cca_pkg::REG_NUM_CLUSTERS) begin
        n_clusters = data;
      end else begin
        n_vertices = data[4:0];
      end
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function bit slot_ok(logic signed [6:0] cid, logic [3:0] vid);
      int c;
      int unsigned nc;
      int unsigned nv;
      c = cid;
      nc = (n_clusters < 64) ? n_clusters : 64;
      nv = (n_vertices < 16) ? n_vertices : 16;
      if (c < 0 || c >= nc) return 0;
      return vid < nv;
    endfunction

    function logic signed [15:0] mean_of(longint s, int unsigned n);
      longint q;
      q = sat(s / longint'(n), -32768, 32767);
      return q[15:0];
    endfunction

    function void note_item(cca_pkg::op_e op, logic signed [6:0] cid, logic [3:0] vid,
                            logic signed [15:0] px, logic signed [15:0] py,
                            logic signed [15:0] pz);
      int k;
      centroid_t e;
      items_seen++;
      k = int'(cid) * 16 + vid;
      case (op)
        cca_pkg::OP_CLEAR: clear_all();
        cca_pkg::OP_ACCUM: begin
          if (slot_ok(cid, vid)) begin
            sum_x[k] = sat(sum_x[k] + px, -64'sd2147483648, 64'sd2147483647);
            sum_y[k] = sat(sum_y[k] + py, -64'sd2147483648, 64'sd2147483647);
            sum_z[k] = sat(sum_z[k] + pz, -64'sd2147483648, 64'sd2147483647);
            if (vid == 0 && members[cid] < 65536) members[cid]++;
          end
        end
        cca_pkg::OP_READ: begin
          e = '0;
          e.empty_cluster = 1'b1;
          if (slot_ok(cid, vid) && members[cid] != 0) begin
            e.mean_x = mean_of(sum_x[k], members[cid]);
            e.mean_y = mean_of(sum_y[k], members[cid]);
            e.mean_z = mean_of(sum_z[k], members[cid]);
            e.member_count = 17'(members[cid]);
            e.empty_cluster = 1'b0;
          end
          waiting = {waiting, e};
        end
        default: ;
      endcase
    endfunction

    function void check_result(centroid_t got);
      centroid_t e;
      if (waiting.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
        return;
      end
      e = waiting.pop_front();
      reads_checked++;
      if (got.mean_x !== e.mean_x) begin
        errors++;
        $display("%0t: mean_x expected %0d actual %0d", $time, e.mean_x, got.mean_x);
      end
      if (got.mean_y !== e.mean_y) begin
        errors++;
        $display("%0t: mean_y expected %0d actual %0d", $time, e.mean_y, got.mean_y);
      end
      if (got.mean_z !== e.mean_z) begin
        errors++;
        $display("%0t: mean_z expected %0d actual %0d", $time, e.mean_z, got.mean_z);
      end
      if (got.member_count !== e.member_count) begin
        errors++;
        $display("%0t: member_count expected %0d actual %0d", $time, e.member_count,
                 got.member_count);
      end
      if (got.empty_cluster !== e.empty_cluster) begin
        errors++;
        $display("%0t: empty_cluster expected %0b actual %0b", $time, e.empty_cluster,
                 got.empty_cluster);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         operation_i;
  logic signed [6:0]  cluster_id_i;
  logic [3:0]         vertex_index_i;
  logic signed [15:0] pos_x_i;
  logic signed [15:0] pos_y_i;
  logic signed [15:0] pos_z_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i;
  logic [6:0]         cfg_data_i;
  logic               result_valid_o;
  logic signed [15:0] mean_x_o;
  logic signed [15:0] mean_y_o;
  logic signed [15:0] mean_z_o;
  logic [16:0]        member_count_o;
  logic               empty_cluster_o;

  centroid_scoreboard sb;
  int                 quiet_cycles;
  int unsigned        phase_nc[6] = '{64, 1, 127, 0, 5, 0};
  int unsigned        phase_nv[6] = '{16, 1, 31, 0, 4, 0};
  int                 phase_idle[6] = '{0, 57, 7, 0, 57, 7};

  cluster_centroid_accumulator DUT (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .cluster_id_i, .vertex_index_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .mean_x_o, .mean_y_o, .mean_z_o, .member_count_o, .empty_cluster_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : monitor
    bit hit;
    hit = 1'b0;
    if (rst_ni) begin
      if (result_valid_o) begin
        sb.check_result('{mean_x_o, mean_y_o, mean_z_o, member_count_o, empty_cluster_o});
        hit = 1'b1;
      end
      if (start && !busy) begin
        sb.note_item(cca_pkg::op_e'(operation_i), cluster_id_i, vertex_index_i,
                     pos_x_i, pos_y_i, pos_z_i);
        hit = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) hit = 1'b1;
      quiet_cycles <= hit ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
        $display("Timeout: no handshake for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic issue(cca_pkg::op_e op, logic signed [6:0] cid, logic [3:0] vid,
                       logic signed [15:0] px, logic signed [15:0] py,
                       logic signed [15:0] pz);
    start <= 1'b1;
    operation_i <= op;
    cluster_id_i <= cid;
    vertex_index_i <= vid;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.waiting.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
  endtask

  task automatic write_reg(cca_pkg::reg_e idx, logic [6:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item(int idle_pct);
    int r;
    int nc;
    int nv;
    cca_pkg::op_e op;
    logic signed [6:0] cid;
    logic [3:0] vid;
    nc = (sb.n_clusters < 8) ? sb.n_clusters : 8;
    nv = (sb.n_vertices < 16) ? sb.n_vertices : 16;
    if (nc < 1) nc = 1;
    if (nv < 1) nv = 1;
    r = $urandom_range(99);
    op = (r < 74) ? cca_pkg::OP_ACCUM : (r < 95) ? cca_pkg::OP_READ :
         (r < 97) ? cca_pkg::OP_CLEAR : cca_pkg::OP_NONE;
    r = $urandom_range(99);
    if (r < 5) cid = -7'sd1;
    else if (r < 10) cid = 7'($urandom_range(127));
    else if (r < 20) cid = 7'($urandom_range(63));
    else cid = 7'($urandom_range(nc - 1));
    r = $urandom_range(99);
    if (r < 30) vid = 4'd0;
    else if (r < 40) vid = 4'($urandom_range(15));
    else vid = 4'($urandom_range(nv - 1));
    issue(op, cid, vid, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
          16'($urandom_range(65535)));
    if ($urandom_range(99) < idle_pct) pause($urandom_range(1, 4));
  endtask

  initial begin
    sb = new();
    quiet_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = cca_pkg::OP_NONE;
    cluster_id_i = '0;
    vertex_index_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = cca_pkg::REG_NUM_CLUSTERS;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(cca_pkg::OP_READ, 7'sd0, 4'd0, 16'sd0, 16'sd0, 16'sd0);
    issue(cca_pkg::OP_ACCUM, 7'sd63, 4'd0, 16'sh7fff, -16'sh8000, 16'sd0);
    issue(cca_pkg::OP_ACCUM, 7'sd63, 4'd15, -16'sh8000, 16'sh7fff, -16'sd1);
    issue(cca_pkg::OP_ACCUM, 7'sd63, 4'd15, -16'sh8000, 16'sh7fff, -16'sd1);
    issue(cca_pkg::OP_ACCUM, 7'sd63, 4'd15, -16'sh8000, 16'sh7fff, -16'sd1);
    issue(cca_pkg::OP_READ, 7'sd63, 4'd15, 16'sd0, 16'sd0, 16'sd0);
    issue(cca_pkg::OP_READ, 7'sd63, 4'd0, 16'sd0, 16'sd0, 16'sd0);
    issue(cca_pkg::OP_ACCUM, -7'sd1, 4'd0, 16'sd100, 16'sd100, 16'sd100);
    issue(cca_pkg::OP_ACCUM, -7'sd64, 4'd0, 16'sd100, 16'sd100, 16'sd100);
    issue(cca_pkg::OP_ACCUM, 7'sd0, 4'd0, 16'sd7, -16'sd7, 16'sd3);
    issue(cca_pkg::OP_ACCUM, 7'sd0, 4'd0, 16'sd0, 16'sd0, 16'sd0);
    issue(cca_pkg::OP_ACCUM, 7'sd0, 4'd1, -16'sd5, 16'sd5, 16'sd1);
    issue(cca_pkg::OP_NONE, 7'sd0, 4'd0, 16'sd9, 16'sd9, 16'sd9);
    issue(cca_pkg::OP_READ, 7'sd0, 4'd0, 16'sd0, 16'sd0, 16'sd0);
    issue(cca_pkg::OP_READ, 7'sd0, 4'd1, 16'sd0, 16'sd0, 16'sd0);
    issue(cca_pkg::OP_READ, -7'sd1, 4'd0, 16'sd0, 16'sd0, 16'sd0);
    issue(cca_pkg::OP_READ, 7'sd5, 4'd3, 16'sd0, 16'sd0, 16'sd0);
    issue(cca_pkg::OP_CLEAR, 7'sd0, 4'd0, 16'sd0, 16'sd0, 16'sd0);
    issue(cca_pkg::OP_READ, 7'sd63, 4'd15, 16'sd0, 16'sd0, 16'sd0);
    issue(cca_pkg::OP_READ, 7'sd0, 4'd0, 16'sd0, 16'sd0, 16'sd0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(cca_pkg::REG_NUM_CLUSTERS,
                7'((p == 5) ? $urandom_range(127) : phase_nc[p]));
      write_reg(cca_pkg::REG_VERTICES, 7'((p == 5) ? $urandom_range(31) : phase_nv[p]));
      @(posedge clk_i);
      for (int i = 0; i < 85; i++) begin
        random_item(phase_idle[p]);
        if (p == 2 && i == 40) drain();
      end
      drain();
    end

    $display("Ran %0d items under six register settings; %0d mean reads compared.",
             sb.items_seen, sb.reads_checked);
    if (sb.errors == 0 && sb.waiting.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

/* files.f */
hw/rtl/cca_pkg.sv
hw/rtl/cca_divider.sv
hw/rtl/cluster_centroid_accumulator.sv
test/tb.sv
